/* sv/ising_wolff_cluster_update_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Wolff cluster update unit
// Clocked implication checks with asynchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef ISING_WOLFF_CLUSTER_UPDATE_UNIT_ASSERT_SVH
`define ISING_WOLFF_CLUSTER_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define IWCU_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IWCU_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/iwcu_pkg.sv */
// ----------------------------------------------------------------------------
// iwcu_pkg
// Field widths, codes and shared types of the Wolff cluster update unit.
// ----------------------------------------------------------------------------
package iwcu_pkg;

	// transaction field widths
	localparam int KIND_W     = 1;
	localparam int SITE_W     = 10;
	localparam int SIZE_W     = 11;
	localparam int MAG_W      = 11;

	// configuration port
	localparam int PROB_W     = 16;
	localparam int SEED_W     = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ADD_PROB = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED = 1'd1;

	localparam logic [PROB_W-1:0] PROB_RST = 16'h8000;
	localparam logic [SEED_W-1:0] RNG_RST  = 32'd1;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_CLUSTER = 1'b0;

	// neighbour directions, visited in this order
	localparam int DIR_W = 2;
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

	// control of the random generator
	typedef struct packed {
		logic              load;
		logic              step;
		logic [SEED_W-1:0] seed;
	} rng_ctrl_t;

endpackage

/* sv/iwcu_cmd_if.sv */
// ----------------------------------------------------------------------------
// iwcu_cmd_if
// Command channel: item kind and lattice site, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iwcu_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [iwcu_pkg::KIND_W-1:0] kind;
	logic [iwcu_pkg::SITE_W-1:0] site;

	modport source (output valid, kind, site, input ready);
	modport sink   (input valid, kind, site, output ready);
endinterface

/* sv/iwcu_res_if.sv */
// ----------------------------------------------------------------------------
// iwcu_res_if
// Result channel: cluster size, spin and |magnetization|, valid/ready.
// ----------------------------------------------------------------------------
interface iwcu_res_if;
	logic                       valid;
	logic                       ready;
	logic [iwcu_pkg::SIZE_W-1:0] cluster_size;
	logic                       spin_up;
	logic [iwcu_pkg::MAG_W-1:0]  abs_magnetization;

	modport source (output valid, cluster_size, spin_up, abs_magnetization, input ready);
	modport sink   (input valid, cluster_size, spin_up, abs_magnetization, output ready);
endinterface

/* sv/iwcu_ram.sv */
// ----------------------------------------------------------------------------
// iwcu_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module iwcu_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/iwcu_nbr.sv */
// ----------------------------------------------------------------------------
// iwcu_nbr
// Periodic neighbour unit: wraps row/column and forms the lattice address.
// ----------------------------------------------------------------------------
module iwcu_nbr #(
	parameter int SIDE = 32,
	localparam int RW  = $clog2(SIDE),
	localparam int AW  = $clog2(SIDE * SIDE)
) (
	input  logic [RW-1:0]                row,
	input  logic [RW-1:0]                col,
	input  logic [iwcu_pkg::DIR_W-1:0]   dir,
	output logic [RW-1:0]                nb_row,
	output logic [RW-1:0]                nb_col,
	output logic [AW-1:0]                nb_addr
);

	localparam logic [RW-1:0] LAST = RW'(SIDE - 1);

	// one step in the chosen direction, wrapping at the edges
	always_comb begin
		nb_row = row;
		nb_col = col;
		case (dir)
			iwcu_pkg::DIR_UP: begin
				nb_row = (row == '0) ? LAST : row - RW'(1);
			end
			iwcu_pkg::DIR_DOWN: begin
				nb_row = (row == LAST) ? '0 : row + RW'(1);
			end
			iwcu_pkg::DIR_LEFT: begin
				nb_col = (col == '0) ? LAST : col - RW'(1);
			end
			iwcu_pkg::DIR_RIGHT: begin
				nb_col = (col == LAST) ? '0 : col + RW'(1);
			end
			default: begin
				nb_row = row;
				nb_col = col;
			end
		endcase
	end

	// row-major address, multiply by a constant
	assign nb_addr = AW'(AW'(nb_row) * AW'(SIDE)) + AW'(nb_col);

endmodule

/* sv/iwcu_rng.sv */
// ----------------------------------------------------------------------------
// iwcu_rng
// xorshift32 generator (13, 17, 5) with bond-probability compare.
// ----------------------------------------------------------------------------
module iwcu_rng (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iwcu_pkg::rng_ctrl_t           ctrl,
	input  logic [iwcu_pkg::PROB_W-1:0]   prob,
	output logic                          hit
);

	logic [iwcu_pkg::SEED_W-1:0] state_q;
	logic [iwcu_pkg::SEED_W-1:0] x1;
	logic [iwcu_pkg::SEED_W-1:0] x2;
	logic [iwcu_pkg::SEED_W-1:0] nxt;

	// next state and draw, upper half of the new state
	always_comb begin
		x1  = state_q ^ (state_q << 13);
		x2  = x1 ^ (x1 >> 17);
		nxt = x2 ^ (x2 << 5);
		hit = nxt[iwcu_pkg::SEED_W-1:iwcu_pkg::SEED_W-iwcu_pkg::PROB_W] < prob;
	end

	// seed load wins over a draw; a zero seed becomes one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iwcu_pkg::RNG_RST;
		end else if (ctrl.load) begin
			state_q <= (ctrl.seed == '0) ? iwcu_pkg::RNG_RST : ctrl.seed;
		end else if (ctrl.step) begin
			state_q <= nxt;
		end
	end

endmodule

/* sv/ising_wolff_cluster_update_unit.sv */
// ----------------------------------------------------------------------------
// ising_wolff_cluster_update_unit
// Wolff cluster flips on a periodic SIDE x SIDE Ising lattice.
// ----------------------------------------------------------------------------
// A cluster transaction (kind 0) flips the seed site and grows the cluster
// through a site stack, testing up, down, left and right neighbours of each
// popped site; a neighbour with the old spin joins when a fresh 16-bit
// xorshift draw is below add_probability. A read transaction (kind 1) returns
// the spin at the site. Both return |magnetization|; a site at or beyond
// SIDE*SIDE changes nothing and returns size 0 and spin 0. After reset the
// lattice is written to its checkerboard while cmd.ready stays low;
// configuration writes are taken at any time but must only be issued while
// the unit is idle. The lattice has a single read port, which checks one
// neighbour per cycle, and each further cluster member adds a stack pop and
// reload.
// ----------------------------------------------------------------------------
module ising_wolff_cluster_update_unit #(
	parameter int SIDE = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [iwcu_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [iwcu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	iwcu_cmd_if.sink                          cmd,
	iwcu_res_if.source                        res
);

	`include "ising_wolff_cluster_update_unit_assert.svh"

	localparam int NSITES = SIDE * SIDE;
	localparam int RW     = $clog2(SIDE);
	localparam int AW     = $clog2(NSITES);
	localparam int SW     = 2 * RW;
	localparam int CW     = AW + 1;
	localparam int MW     = AW + 2;
	localparam int CMPW   = iwcu_pkg::SITE_W + AW + 1;

	// site / SIDE by reciprocal multiply and one correction
	localparam int DIV_K  = 20;
	localparam int PROD_W = iwcu_pkg::SITE_W + DIV_K;
	localparam int DW     = iwcu_pkg::SITE_W + RW + 1;
	localparam logic [DIV_K-1:0] RECIP = DIV_K'((1 << DIV_K) / SIDE);

	localparam logic signed [MW-1:0] MSUM_RST = MW'(NSITES % 2);
	localparam logic [AW-1:0] LAST_SITE = AW'(NSITES - 1);
	localparam logic [RW-1:0] LAST_RC   = RW'(SIDE - 1);

	// sequencer states
	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_SEED = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_NB0  = 4'd4;
	localparam logic [3:0] S_CHK  = 4'd5;
	localparam logic [3:0] S_POP  = 4'd6;
	localparam logic [3:0] S_LOAD = 4'd7;
	localparam logic [3:0] S_MAG  = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]                   state_q;
	logic [AW-1:0]                init_addr_q;
	logic [RW-1:0]                init_row_q;
	logic [RW-1:0]                init_col_q;
	logic [iwcu_pkg::PROB_W-1:0]  add_prob_q;
	logic signed [MW-1:0]         msum_q;
	logic                         res_valid_q;

	logic [iwcu_pkg::KIND_W-1:0]  kind_q;
	logic [iwcu_pkg::SITE_W-1:0]  site_q;
	logic                         site_ok_q;
	logic                         clus_q;
	logic                         old_q;
	logic                         spin_q;
	logic [PROD_W-1:0]            prod_s1;
	logic [RW-1:0]                cur_row_q;
	logic [RW-1:0]                cur_col_q;
	logic [RW-1:0]                nb_row_q;
	logic [RW-1:0]                nb_col_q;
	logic [AW-1:0]                nb_addr_q;
	logic [iwcu_pkg::DIR_W-1:0]   dir_q;
	logic [AW-1:0]                sh_q;
	logic [AW-1:0]                sp_q;
	logic [iwcu_pkg::SIZE_W-1:0]  res_size_q;
	logic                         res_spin_q;
	logic [iwcu_pkg::MAG_W-1:0]   res_mag_q;

	logic                         cmd_acc;
	logic                         res_free;
	logic                         res_load;
	logic                         clus_done;
	logic                         clus_now;
	logic                         same;
	logic                         join_nb;
	logic [AW-1:0]                sh_next;
	logic                         grow_done;
	logic [CW-1:0]                count;
	logic [MW-1:0]                dbl;
	logic [MW-1:0]                mag_abs;
	logic                         site_ok;

	logic [iwcu_pkg::SITE_W-1:0]  q_est;
	logic [DW-1:0]                rem;
	logic                         rem_fix;
	logic [RW-1:0]                div_row;
	logic [RW-1:0]                div_col;

	logic                         lat_we;
	logic [AW-1:0]                lat_waddr;
	logic                         lat_wdata;
	logic [AW-1:0]                lat_raddr;
	logic                         lat_rdata;
	logic                         stk_we;
	logic [SW-1:0]                stk_rdata;

	logic [iwcu_pkg::DIR_W-1:0]   nbr_dir;
	logic [RW-1:0]                nbr_row;
	logic [RW-1:0]                nbr_col;
	logic [AW-1:0]                nbr_addr;
	logic                         rng_hit;
	iwcu_pkg::rng_ctrl_t          rng_ctrl;

	// handshake and item decode
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && (state_q == S_IDLE);
	assign res_free  = !res_valid_q || res.ready;
	assign res_load  = (state_q == S_DONE) && res_free;
	assign clus_done = (state_q == S_DONE) && clus_q;
	assign site_ok   = CMPW'(cmd.site) < CMPW'(NSITES);
	assign clus_now  = site_ok_q && (kind_q == iwcu_pkg::KIND_CLUSTER);

	// growth bookkeeping
	assign same      = (lat_rdata == old_q);
	assign join_nb   = same && rng_hit && (sh_q != LAST_SITE);
	assign sh_next   = join_nb ? sh_q + AW'(1) : sh_q;
	assign grow_done = (sp_q == sh_next);
	assign count     = CW'(sh_q) + CW'(1);
	assign dbl       = MW'({count, 1'b0});
	assign mag_abs   = msum_q[MW-1] ? MW'(-msum_q) : MW'(msum_q);

	// quotient correction of the seed site
	always_comb begin
		q_est   = prod_s1[PROD_W-1:DIV_K];
		rem     = DW'(site_q) - DW'(DW'(q_est) * DW'(SIDE));
		rem_fix = rem >= DW'(SIDE);
		div_row = rem_fix ? RW'(q_est + iwcu_pkg::SITE_W'(1)) : RW'(q_est);
		div_col = rem_fix ? RW'(rem - DW'(SIDE)) : RW'(rem);
	end

	// memory port and neighbour selection
	always_comb begin
		lat_we    = 1'b0;
		lat_waddr = nb_addr_q;
		lat_wdata = ~old_q;
		lat_raddr = nbr_addr;
		stk_we    = 1'b0;
		nbr_dir   = iwcu_pkg::DIR_UP;
		case (state_q)
			S_INIT: begin
				lat_we    = 1'b1;
				lat_waddr = init_addr_q;
				lat_wdata = ~(init_row_q[0] ^ init_col_q[0]);
			end
			S_IDLE: begin
				lat_raddr = AW'(cmd.site);
			end
			S_SEED: begin
				lat_we    = clus_now;
				lat_waddr = AW'(site_q);
				lat_wdata = ~lat_rdata;
			end
			S_CHK: begin
				lat_we = join_nb;
				stk_we = join_nb;
				if (dir_q != iwcu_pkg::DIR_RIGHT) begin
					nbr_dir = dir_q + iwcu_pkg::DIR_W'(1);
				end
			end
			default: begin
				lat_we = 1'b0;
			end
		endcase
	end

	// random generator control
	always_comb begin
		rng_ctrl.load = cfg_we && (cfg_idx == iwcu_pkg::REG_RNG_SEED);
		rng_ctrl.seed = cfg_wdata[iwcu_pkg::SEED_W-1:0];
		rng_ctrl.step = (state_q == S_CHK) && same;
	end

	iwcu_ram #(
		.WIDTH (1),
		.DEPTH (NSITES)
	) u_lattice (
		.clk   (clk),
		.we    (lat_we),
		.waddr (lat_waddr),
		.wdata (lat_wdata),
		.raddr (lat_raddr),
		.rdata (lat_rdata)
	);

	iwcu_ram #(
		.WIDTH (SW),
		.DEPTH (NSITES)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sh_q + AW'(1)),
		.wdata ({nb_row_q, nb_col_q}),
		.raddr (sp_q),
		.rdata (stk_rdata)
	);

	iwcu_nbr #(
		.SIDE (SIDE)
	) u_nbr (
		.row     (cur_row_q),
		.col     (cur_col_q),
		.dir     (nbr_dir),
		.nb_row  (nbr_row),
		.nb_col  (nbr_col),
		.nb_addr (nbr_addr)
	);

	iwcu_rng u_rng (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rng_ctrl),
		.prob   (add_prob_q),
		.hit    (rng_hit)
	);

	// sequencer, checkerboard initialisation pass, running sum and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_addr_q <= '0;
			init_row_q  <= '0;
			init_col_q  <= '0;
			add_prob_q  <= iwcu_pkg::PROB_RST;
			msum_q      <= MSUM_RST;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_idx == iwcu_pkg::REG_ADD_PROB)) begin
				add_prob_q <= cfg_wdata[iwcu_pkg::PROB_W-1:0];
			end
			// a new result replaces the taken one in the same cycle
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_addr_q <= init_addr_q + AW'(1);
					if (init_col_q == LAST_RC) begin
						init_col_q <= '0;
						init_row_q <= init_row_q + RW'(1);
					end else begin
						init_col_q <= init_col_q + RW'(1);
					end
					if (init_addr_q == LAST_SITE) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_acc) begin
						state_q <= S_SEED;
					end
				end
				S_SEED: begin
					state_q <= clus_now ? S_DIV : S_DONE;
				end
				S_DIV: begin
					state_q <= S_NB0;
				end
				S_NB0: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (dir_q == iwcu_pkg::DIR_RIGHT) begin
						state_q <= grow_done ? S_MAG : S_POP;
					end
				end
				S_POP: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_NB0;
				end
				S_MAG: begin
					msum_q  <= spin_q ? msum_q + $signed(dbl) : msum_q - $signed(dbl);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					kind_q    <= cmd.kind;
					site_q    <= cmd.site;
					site_ok_q <= site_ok;
				end
			end
			S_SEED: begin
				clus_q  <= clus_now;
				old_q   <= lat_rdata;
				spin_q  <= site_ok_q && (clus_now ? ~lat_rdata : lat_rdata);
				prod_s1 <= PROD_W'(site_q) * PROD_W'(RECIP);
				sh_q    <= '0;
				sp_q    <= '0;
			end
			S_DIV: begin
				cur_row_q <= div_row;
				cur_col_q <= div_col;
			end
			S_NB0: begin
				nb_row_q  <= nbr_row;
				nb_col_q  <= nbr_col;
				nb_addr_q <= nbr_addr;
				dir_q     <= iwcu_pkg::DIR_UP;
			end
			S_CHK: begin
				sh_q <= sh_next;
				if (dir_q != iwcu_pkg::DIR_RIGHT) begin
					nb_row_q  <= nbr_row;
					nb_col_q  <= nbr_col;
					nb_addr_q <= nbr_addr;
					dir_q     <= dir_q + iwcu_pkg::DIR_W'(1);
				end else if (!grow_done) begin
					sp_q <= sp_q + AW'(1);
				end
			end
			S_LOAD: begin
				cur_row_q <= stk_rdata[SW-1:RW];
				cur_col_q <= stk_rdata[RW-1:0];
			end
			S_DONE: begin
				if (res_free) begin
					res_size_q <= clus_q ? iwcu_pkg::SIZE_W'(count) : '0;
					res_spin_q <= spin_q;
					res_mag_q  <= iwcu_pkg::MAG_W'(mag_abs);
				end
			end
			default: begin
				res_spin_q <= res_spin_q;
			end
		endcase
	end

	assign res.valid             = res_valid_q;
	assign res.cluster_size      = res_size_q;
	assign res.spin_up           = res_spin_q;
	assign res.abs_magnetization = res_mag_q;

	// checks on the growth loop, the seed flip, the running sum and the result valid
	`IWCU_ASSERT_IMP(a_stack_order, clk, arst_n, state_q == S_CHK, sp_q <= sh_q, "pop past top")
	`IWCU_ASSERT_IMP(a_msum_parity, clk, arst_n, 1'b1, msum_q[0] == MSUM_RST[0], "parity lost")
	`IWCU_ASSERT_IMP(a_seed_flipped, clk, arst_n, clus_done, spin_q != old_q, "seed kept")
	`IWCU_ASSERT_NXT(a_res_from_done, clk, arst_n, res_load, res_valid_q, "result lost")
	`IWCU_ASSERT_NXT(a_mag_moves, clk, arst_n, state_q == S_MAG, $changed(msum_q), "sum kept")

endmodule
